// File: design/mer_pkg.sv
// ============================================================================
// mer_pkg
// Shared constants, operation codes and controller/datapath interface types
// for the midpoint ellipse rasterizer.
// ============================================================================
package mer_pkg;

    // Default radius width in bits.
    localparam int RADIUS_BITS_DEF = 8;

    // Centre registers and output coordinates.
    localparam int                  CENTER_W     = 10;
    localparam logic [CENTER_W-1:0] CENTER_RESET = 10'd200;
    localparam int                  COORD_W      = 12;
    localparam int                  N_POINTS     = 4;
    localparam int                  OUT_DATA_W   = 2 * N_POINTS * COORD_W;

    // Configuration register indexes.
    localparam int                   CFG_IDX_W    = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 1'b1;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Operations of the shared multiplier.
    localparam int MUL_OP_W = 4;
    typedef logic [MUL_OP_W-1:0] t_mul_op;

    localparam t_mul_op MUL_NONE    = 4'd0;  // idle
    localparam t_mul_op MUL_RX_RX   = 4'd1;  // rx * rx
    localparam t_mul_op MUL_RY_RY   = 4'd2;  // ry * ry
    localparam t_mul_op MUL_RX2_RY  = 4'd3;  // rx^2 * ry
    localparam t_mul_op MUL_TX_TX   = 4'd4;  // (2x+1)^2
    localparam t_mul_op MUL_RY2_P   = 4'd5;  // ry^2 * previous product
    localparam t_mul_op MUL_TY_TY   = 4'd6;  // (y-1)^2
    localparam t_mul_op MUL_RX2_P   = 4'd7;  // rx^2 * previous product
    localparam t_mul_op MUL_RX2_RY2 = 4'd8;  // rx^2 * ry^2

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    cap;     // input transfer: capture the pending result
        logic    start;   // input transfer of a start item: load the radii
        logic    step;    // advance the midpoint decision by one step
        t_mul_op mul_op;  // multiplier operation issued this cycle
        logic    emit;    // move the pending result to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;       // an ellipse is being traced
        logic y_zero;     // current vertical offset is zero
        logic step_last;  // the step in progress brings y to zero
        logic need_sw;    // the step in progress hands over to region two
        logic out_free;   // output register can take a result this cycle
    } t_stat;

endpackage

// File: design/mer_ctrl.sv
// ============================================================================
// mer_ctrl
// Sequencing state machine: accepts one item at a time, runs the multiplier
// schedules for start and region switch, and hands results to the output.
// ============================================================================
module mer_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_kind,
    output logic           o_in_ready,
    input  mer_pkg::t_stat i_stat,
    output mer_pkg::t_cmd  o_cmd
);
    import mer_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ST0  = 4'd1;
    localparam logic [3:0] S_ST1  = 4'd2;
    localparam logic [3:0] S_ST2  = 4'd3;
    localparam logic [3:0] S_ST3  = 4'd4;
    localparam logic [3:0] S_STEP = 4'd5;
    localparam logic [3:0] S_SW0  = 4'd6;
    localparam logic [3:0] S_SW1  = 4'd7;
    localparam logic [3:0] S_SW2  = 4'd8;
    localparam logic [3:0] S_SW3  = 4'd9;
    localparam logic [3:0] S_SW4  = 4'd10;
    localparam logic [3:0] S_SW5  = 4'd11;
    localparam logic [3:0] S_EMIT = 4'd12;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and commands.
    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_cmd.mul_op = MUL_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.cap = 1'b1;
                    if (i_in_kind == KIND_START) begin
                        o_cmd.start = 1'b1;
                        n_state     = S_ST0;
                    end else if (i_stat.busy && !i_stat.y_zero) begin
                        n_state = S_STEP;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            // Start: squares of the radii, then rx^2 * ry.
            S_ST0: begin
                o_cmd.mul_op = MUL_RX_RX;
                n_state      = S_ST1;
            end
            S_ST1: begin
                o_cmd.mul_op = MUL_RY_RY;
                n_state      = S_ST2;
            end
            S_ST2: begin
                o_cmd.mul_op = MUL_RX2_RY;
                n_state      = S_ST3;
            end
            S_ST3: begin
                n_state = S_EMIT;
            end
            S_STEP: begin
                o_cmd.step = 1'b1;
                if (i_stat.need_sw && !i_stat.step_last) begin
                    n_state = S_SW0;
                end else begin
                    n_state = S_EMIT;
                end
            end
            // Region switch: rebuild the decision from the current offsets.
            S_SW0: begin
                o_cmd.mul_op = MUL_TX_TX;
                n_state      = S_SW1;
            end
            S_SW1: begin
                o_cmd.mul_op = MUL_RY2_P;
                n_state      = S_SW2;
            end
            S_SW2: begin
                o_cmd.mul_op = MUL_TY_TY;
                n_state      = S_SW3;
            end
            S_SW3: begin
                o_cmd.mul_op = MUL_RX2_P;
                n_state      = S_SW4;
            end
            S_SW4: begin
                o_cmd.mul_op = MUL_RX2_RY2;
                n_state      = S_SW5;
            end
            S_SW5: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/mer_dp.sv
// ============================================================================
// mer_dp
// Datapath: centre registers, ellipse state, the shared multiplier, the
// step adder and the pending and output result registers.
// ============================================================================
module mer_dp #(
    parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mer_pkg::t_cmd                   i_cmd,
    output mer_pkg::t_stat                  o_stat,
    input  logic                            i_kind,
    input  logic [RADIUS_BITS-1:0]          i_radius_x,
    input  logic [RADIUS_BITS-1:0]          i_radius_y,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mer_pkg::CENTER_W-1:0]    i_cfg_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_out_user,
    output logic                            o_out_last,
    output logic [mer_pkg::OUT_DATA_W-1:0]  o_out_data
);
    import mer_pkg::*;

    localparam int RB    = RADIUS_BITS;
    localparam int SQ_W  = 2 * RB;
    localparam int SD_W  = 3 * RB + 2;
    localparam int DEC_W = 5 * RB;
    localparam int MA_W  = 2 * RB;
    localparam int MB_W  = 2 * RB + 2;
    localparam int P_W   = MA_W + MB_W;
    localparam logic [RB-1:0] RAD_MAX = {RB{1'b1}};

    // Control registers.
    logic [CENTER_W-1:0] r_cx, r_cy;
    logic                r_busy, n_busy;
    logic                r_reg2, n_reg2;
    t_mul_op             r_prod_op;
    logic                r_out_valid, n_out_valid;

    // Payload registers.
    logic [RB-1:0]            r_rad_x, n_rad_x;
    logic [RB-1:0]            r_off_x, n_off_x;
    logic [RB-1:0]            r_off_y, n_off_y;
    logic [SQ_W-1:0]          r_rx2, n_rx2;
    logic [SQ_W-1:0]          r_ry2, n_ry2;
    logic [SD_W-1:0]          r_sdx, n_sdx;
    logic [SD_W-1:0]          r_sdy, n_sdy;
    logic signed [DEC_W-1:0]  r_dec, n_dec;
    logic [P_W-1:0]           r_prod;
    logic                     r_pend_valid, n_pend_valid;
    logic                     r_pend_last, n_pend_last;
    logic [OUT_DATA_W-1:0]    r_pend_data, n_pend_data;
    logic                     r_out_user, n_out_user;
    logic                     r_out_last, n_out_last;
    logic [OUT_DATA_W-1:0]    r_out_data, n_out_data;

    // Working signals.
    logic [MA_W-1:0]          mul_a;
    logic [MB_W-1:0]          mul_b;
    logic [RB:0]              tx;
    logic [RB-1:0]            ty;
    logic signed [DEC_W-1:0]  prod_ext, prod_x4;
    logic                     x_step, y_step;
    logic [RB-1:0]            stp_x, stp_y;
    logic [SD_W-1:0]          stp_sdx, stp_sdy;
    logic signed [DEC_W-1:0]  a_term, b_term, c_term, term;
    logic                     y_zero, pend_ok;
    logic [COORD_W-1:0]       cxe, cye, xe, ye;
    logic [OUT_DATA_W-1:0]    pts;

    assign o_cfg_ready = 1'b1;
    assign y_zero      = (r_off_y == '0);
    assign tx          = {r_off_x, 1'b1};
    assign ty          = r_off_y - 1'b1;
    assign prod_ext    = DEC_W'(r_prod);
    assign prod_x4     = DEC_W'({r_prod, 2'b00});

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.mul_op)
            MUL_RX_RX: begin
                mul_a = MA_W'(r_rad_x);
                mul_b = MB_W'(r_rad_x);
            end
            MUL_RY_RY: begin
                mul_a = MA_W'(r_off_y);
                mul_b = MB_W'(r_off_y);
            end
            MUL_RX2_RY: begin
                mul_a = r_rx2;
                mul_b = MB_W'(r_off_y);
            end
            MUL_TX_TX: begin
                mul_a = MA_W'(tx);
                mul_b = MB_W'(tx);
            end
            MUL_RY2_P: begin
                mul_a = r_ry2;
                mul_b = r_prod[MB_W-1:0];
            end
            MUL_TY_TY: begin
                mul_a = MA_W'(ty);
                mul_b = MB_W'(ty);
            end
            MUL_RX2_P: begin
                mul_a = r_rx2;
                mul_b = r_prod[MB_W-1:0];
            end
            MUL_RX2_RY2: begin
                mul_a = r_rx2;
                mul_b = MB_W'(r_ry2);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // One midpoint step: which offsets move and the decision increment.
    always_comb begin
        x_step  = r_reg2 ? !(r_dec > 0) : 1'b1;
        y_step  = r_reg2 ? 1'b1 : !(r_dec < 0);
        stp_x   = (x_step && (r_off_x != RAD_MAX)) ? r_off_x + 1'b1 : r_off_x;
        stp_sdx = x_step ? r_sdx + SD_W'({r_ry2, 1'b0}) : r_sdx;
        stp_y   = y_step ? r_off_y - 1'b1 : r_off_y;
        stp_sdy = y_step ? r_sdy - SD_W'({r_rx2, 1'b0}) : r_sdy;
        a_term  = x_step ? DEC_W'(stp_sdx) : '0;
        b_term  = y_step ? DEC_W'(stp_sdy) : '0;
        c_term  = r_reg2 ? DEC_W'(r_rx2) : DEC_W'(r_ry2);
        term    = a_term - b_term + c_term;
    end

    // The four mirrored points of the current offset, wrapped to 12 bits.
    always_comb begin
        cxe = COORD_W'(r_cx);
        cye = COORD_W'(r_cy);
        xe  = COORD_W'(r_off_x);
        ye  = COORD_W'(r_off_y);
        pts = {cye + ye, cxe - xe, cye - ye, cxe + xe,
               cye - ye, cxe - xe, cye + ye, cxe + xe};
    end

    assign pend_ok = (i_kind == KIND_STEP) && r_busy;

    // Next values of state and result registers.
    always_comb begin
        n_busy       = r_busy;
        n_reg2       = r_reg2;
        n_rad_x      = r_rad_x;
        n_off_x      = r_off_x;
        n_off_y      = r_off_y;
        n_rx2        = r_rx2;
        n_ry2        = r_ry2;
        n_sdx        = r_sdx;
        n_sdy        = r_sdy;
        n_dec        = r_dec;
        n_pend_valid = r_pend_valid;
        n_pend_last  = r_pend_last;
        n_pend_data  = r_pend_data;
        n_out_valid  = r_out_valid;
        n_out_user   = r_out_user;
        n_out_last   = r_out_last;
        n_out_data   = r_out_data;

        // Input transfer: result from the current offsets.
        if (i_cmd.cap) begin
            n_pend_valid = pend_ok;
            n_pend_last  = pend_ok && y_zero;
            n_pend_data  = pend_ok ? pts : '0;
            if (pend_ok && y_zero) begin
                n_busy = 1'b0;
            end
        end

        if (i_cmd.start) begin
            n_rad_x = i_radius_x;
            n_off_x = '0;
            n_off_y = i_radius_y;
            n_sdx   = '0;
            n_reg2  = 1'b0;
            n_busy  = 1'b1;
        end

        if (i_cmd.step) begin
            n_off_x = stp_x;
            n_off_y = stp_y;
            n_sdx   = stp_sdx;
            n_sdy   = stp_sdy;
            n_dec   = r_dec + (term <<< 2);
            if (stp_y == '0) begin
                n_busy      = 1'b0;
                n_pend_last = 1'b1;
            end
        end

        // Consume the product issued in the previous cycle.
        case (r_prod_op)
            MUL_RX_RX: n_rx2 = r_prod[SQ_W-1:0];
            MUL_RY_RY: n_ry2 = r_prod[SQ_W-1:0];
            MUL_RX2_RY: begin
                n_sdy = {r_prod[SD_W-2:0], 1'b0};
                n_dec = DEC_W'({r_ry2, 2'b00}) - prod_x4 + DEC_W'(r_rx2);
            end
            MUL_RY2_P:   n_dec = prod_ext;
            MUL_RX2_P:   n_dec = r_dec + prod_x4;
            MUL_RX2_RY2: begin
                n_dec  = r_dec - prod_x4;
                n_reg2 = 1'b1;
            end
            default: ;
        endcase

        // Output register.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.emit) begin
            n_out_valid = 1'b1;
            n_out_user  = r_pend_valid;
            n_out_last  = r_pend_last;
            n_out_data  = r_pend_data;
        end
    end

    // Control registers with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx        <= CENTER_RESET;
            r_cy        <= CENTER_RESET;
            r_busy      <= 1'b0;
            r_reg2      <= 1'b0;
            r_prod_op   <= MUL_NONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_CENTER_X: r_cx <= i_cfg_data;
                    CFG_CENTER_Y: r_cy <= i_cfg_data;
                    default: ;
                endcase
            end
            r_busy      <= n_busy;
            r_reg2      <= n_reg2;
            r_prod_op   <= i_cmd.mul_op;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rad_x      <= n_rad_x;
        r_off_x      <= n_off_x;
        r_off_y      <= n_off_y;
        r_rx2        <= n_rx2;
        r_ry2        <= n_ry2;
        r_sdx        <= n_sdx;
        r_sdy        <= n_sdy;
        r_dec        <= n_dec;
        r_prod       <= P_W'(mul_a) * P_W'(mul_b);
        r_pend_valid <= n_pend_valid;
        r_pend_last  <= n_pend_last;
        r_pend_data  <= n_pend_data;
        r_out_user   <= n_out_user;
        r_out_last   <= n_out_last;
        r_out_data   <= n_out_data;
    end

    assign o_stat.busy      = r_busy;
    assign o_stat.y_zero    = y_zero;
    assign o_stat.step_last = (stp_y == '0);
    assign o_stat.need_sw   = !r_reg2 && !(stp_sdx < stp_sdy);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_out_user;
    assign o_out_last  = r_out_last;
    assign o_out_data  = r_out_data;

endmodule

// File: design/midpoint_ellipse_rasterizer.sv
// ============================================================================
// midpoint_ellipse_rasterizer
// Traces an ellipse around a programmable centre with the two-region
// midpoint algorithm and delivers four mirrored pixels per step.
// ============================================================================
// Usage:
//   Input stream: s_axis_tuser is the item kind (0 start, 1 step); tdata
//   carries radius_x in the low RADIUS_BITS bits and radius_y above it.
//   Output stream: one result per input item. tuser is valid_res, tlast
//   marks the final step of the ellipse, tdata holds the four points.
//   A start item, or a step with no ellipse running, gives an all-zero
//   result with tuser low.
//   Configuration: a write on the cfg channel sets center_x (index 0) or
//   center_y (index 1); the channel is always ready. Write only while idle.
//   Timing: one item in flight. An ordinary step goes through the step
//   state to the result and a step with nothing to advance goes straight
//   to it; a start and the step that enters region two pass through a
//   sequence of products on the one shared multiplier before the result.
//   The next item is taken once the result is in the output register,
//   even while the receiver stalls it; a stalled result holds the block
//   before its next result.
//   Reset clears the tracer to idle and the centre to (200, 200).
// ============================================================================
module midpoint_ellipse_rasterizer #(
    parameter int  RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
    localparam int IN_DATA_W   = ((2 * RADIUS_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream.
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [IN_DATA_W-1:0]           s_axis_tdata,  // radius_x, radius_y
    input  logic                           s_axis_tuser,  // kind
    // Output stream.
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // point_a_x, point_a_y, point_b_x, point_b_y,
    // point_c_x, point_c_y, point_d_x, point_d_y
    output logic [mer_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tuser,  // valid_res
    output logic                           m_axis_tlast,  // last
    // Configuration write channel.
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mer_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mer_pkg::CENTER_W-1:0]   i_cfg_data
);
    import mer_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer.
    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_kind  (s_axis_tuser),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // Arithmetic and result registers.
    mer_dp #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_kind      (s_axis_tuser),
        .i_radius_x  (s_axis_tdata[RADIUS_BITS-1:0]),
        .i_radius_y  (s_axis_tdata[2*RADIUS_BITS-1:RADIUS_BITS]),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_user  (m_axis_tuser),
        .o_out_last  (m_axis_tlast),
        .o_out_data  (m_axis_tdata)
    );

endmodule

// File: design/mer_checker.sv
// ============================================================================
// mer_checker
// Port-level checks for the midpoint ellipse rasterizer, bound to the top.
// ============================================================================
module mer_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic        m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result keeps its valid and payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled output changed");

    // Only one item is in flight: an input transfer leaves the input not ready.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken on consecutive cycles");

    // The last step of an ellipse is always a meaningful result.
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("last flag on an empty result");

    // A result without valid points carries zeros.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
        else $error("empty result carries data");

    // The four points mirror one offset, so their coordinates pair up.
    a_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            m_axis_tdata[11:0] == m_axis_tdata[59:48]
            && m_axis_tdata[23:12] == m_axis_tdata[95:84]
            && m_axis_tdata[35:24] == m_axis_tdata[83:72]
            && m_axis_tdata[47:36] == m_axis_tdata[71:60])
        else $error("points are not mirrored");

endmodule

bind midpoint_ellipse_rasterizer mer_checker u_mer_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);
